/* design/bit_pkg.sv */
`default_nettype none

package bit_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Neighbor reads per interior pixel: the 3x3 window, then (r+2,c) and (r,c+2).
    localparam int          NB_COUNT = 11;
    localparam logic [3:0]  NB_LAST  = 4'(NB_COUNT - 1);
    localparam int          MASK_COUNT = 8;

    // Window bit m*3+n holds the pixel at (r-1+m, c-1+n).
    localparam logic [8:0] MASK_CARE [MASK_COUNT] = '{
        9'b010111111, 9'b011111011, 9'b111111010, 9'b110111110,
        9'b010111110, 9'b010111011, 9'b011111010, 9'b110111010
    };
    localparam logic [8:0] MASK_VAL [MASK_COUNT] = '{
        9'b010111000, 9'b010110010, 9'b000111010, 9'b010011010,
        9'b010011000, 9'b010110000, 9'b000110010, 9'b000011010
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic item_write;
        logic item_read;
        logic out_load_item;
        logic out_load_rd;
        logic start_run;
        logic gather_start;
        logic issue;
        logic zero_write;
        logic eval_write;
        logic finish_pass;
        logic run_done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic interior;
        logic last_pixel;
        logic k_last;
        logic changed;
        logic out_valid;
    } t_status;

    // Row offset of neighbor read k.
    function automatic int nb_dr(input logic [3:0] k);
        int d;
        unique case (k) inside
            [4'd0:4'd2]: d = -1;
            [4'd3:4'd5]: d = 0;
            [4'd6:4'd8]: d = 1;
            4'd9:        d = 2;
            default:     d = 0;
        endcase
        return d;
    endfunction

    // Column offset of neighbor read k.
    function automatic int nb_dc(input logic [3:0] k);
        int d;
        unique case (k) inside
            4'd0, 4'd3, 4'd6: d = -1;
            4'd1, 4'd4, 4'd7: d = 0;
            4'd2, 4'd5, 4'd8: d = 1;
            4'd10:            d = 2;
            default:          d = 0;
        endcase
        return d;
    endfunction

    // True if the window matches any of the removal masks.
    function automatic logic any_mask(input logic [8:0] win);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < MASK_COUNT; i++) begin
            if ((win & MASK_CARE[i]) == MASK_VAL[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Two-pixel restore test on the window plus the two far neighbors.
    function automatic logic restore(input logic [10:0] win);
        logic vert;
        logic horz;
        vert = !win[1] && win[4] && win[7] && !win[9];
        horz = !win[3] && win[4] && win[5] && !win[10];
        return vert || horz;
    endfunction

endpackage

`default_nettype wire

/* design/bit_ram.sv */
`default_nettype none

module bit_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/bit_ctrl.sv */
`default_nettype none

module bit_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [1:0]      i_op,
    input  wire logic            i_m_tready,
    input  wire bit_pkg::t_status i_status,
    output bit_pkg::t_cmd        o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDWAIT = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_GATHER = 3'd3;
    localparam logic [2:0] ST_LAST   = 3'd4;
    localparam logic [2:0] ST_EVAL   = 3'd5;
    localparam logic [2:0] ST_PEND   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    // Items are taken only when idle and the output register will be free.
    assign o_s_tready = (r_state == ST_IDLE) && (!i_status.out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        bit_pkg::OP_WRITE: begin
                            o_cmd.item_write    = 1'b1;
                            o_cmd.out_load_item = 1'b1;
                        end
                        bit_pkg::OP_READ: begin
                            o_cmd.item_read = 1'b1;
                            n_state         = ST_RDWAIT;
                        end
                        bit_pkg::OP_RUN: begin
                            o_cmd.start_run = 1'b1;
                            n_state         = ST_SCAN;
                        end
                        default: begin
                            o_cmd.out_load_item = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                o_cmd.out_load_rd = 1'b1;
                n_state           = ST_IDLE;
            end
            ST_SCAN: begin
                if (i_status.interior) begin
                    o_cmd.gather_start = 1'b1;
                    n_state            = ST_GATHER;
                end else begin
                    o_cmd.zero_write = 1'b1;
                    n_state          = i_status.last_pixel ? ST_PEND : ST_SCAN;
                end
            end
            ST_GATHER: begin
                o_cmd.issue = 1'b1;
                if (i_status.k_last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval_write = 1'b1;
                n_state          = i_status.last_pixel ? ST_PEND : ST_SCAN;
            end
            ST_PEND: begin
                o_cmd.finish_pass = 1'b1;
                n_state           = i_status.changed ? ST_SCAN : ST_DONE;
            end
            ST_DONE: begin
                o_cmd.run_done = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // At most one store write is commanded per cycle.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.item_write, o_cmd.zero_write, o_cmd.eval_write}))
        else $error("conflicting store writes");

    // A read item always delivers its result in the following cycle.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.item_read |=> o_cmd.out_load_rd)
        else $error("read result not loaded");

    // A pass ends either in a new pass or in the run result.
    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish_pass |=> (r_state == ST_SCAN || r_state == ST_DONE))
        else $error("bad state after pass");

    // No item is taken while a read or a run is in progress.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_s_tready)
        else $error("ready while busy");

endmodule

`default_nettype wire

/* design/bit_dp.sv */
`default_nettype none

module bit_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [8:0]    i_cfg_data,
    input  wire logic [7:0]    i_row,
    input  wire logic [7:0]    i_column,
    input  wire logic          i_pixel_value,
    input  wire logic          i_m_tready,
    input  wire bit_pkg::t_cmd i_cmd,
    output bit_pkg::t_status   o_status,
    output logic               o_out_valid,
    output logic               o_read_pixel,
    output logic [15:0]        o_pass_count
);

    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [8:0]    r_cfg_w;
    logic [8:0]    r_cfg_h;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [3:0]    r_k;
    logic          r_cap_v;
    logic [3:0]    r_cap_k;
    logic [10:0]   r_win;
    logic          r_cur;
    logic          r_changed;
    logic [15:0]   r_count;
    logic [15:0]   r_passes;
    logic          r_rd_ok;
    logic          r_out_valid;
    logic          r_out_pix;
    logic [15:0]   r_out_cnt;

    int            hv;
    int            wv;
    int            rr;
    int            cc;
    logic          item_inside;
    logic [AW-1:0] item_addr;
    logic [AW-1:0] scan_addr;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          wdata;
    logic          pass_we;
    logic          keep;
    logic          removed;
    logic          restore_ok;
    logic          rdata0;
    logic          rdata1;
    logic          rdata;
    logic          we0;
    logic          we1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 9'd256;
            r_cfg_h <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_idx) begin
                r_cfg_h <= i_cfg_data;
            end else begin
                r_cfg_w <= i_cfg_data;
            end
        end
    end

    // Clamped dimensions, addresses and neighbor position.
    always_comb begin
        hv = int'(r_cfg_h);
        wv = int'(r_cfg_w);
        if (hv < 1) hv = 1;
        if (hv > MAX_HEIGHT) hv = MAX_HEIGHT;
        if (wv < 1) wv = 1;
        if (wv > MAX_WIDTH) wv = MAX_WIDTH;
        item_inside = (int'(i_row) < MAX_HEIGHT) && (int'(i_column) < MAX_WIDTH);
        item_addr   = item_inside ? AW'(int'(i_row) * MAX_WIDTH + int'(i_column)) : '0;
        scan_addr   = AW'(int'(r_row) * MAX_WIDTH + int'(r_col));
        rr = int'(r_row) + bit_pkg::nb_dr(r_k);
        cc = int'(r_col) + bit_pkg::nb_dc(r_k);
        if (rr < MAX_HEIGHT && cc < MAX_WIDTH) begin
            nb_addr = AW'(rr * MAX_WIDTH + cc);
        end else begin
            nb_addr = '0;
        end
    end

    assign o_status.interior   = (int'(r_row) >= 1) && (int'(r_row) + 1 < hv) &&
                                 (int'(r_col) >= 1) && (int'(r_col) + 1 < wv);
    assign o_status.last_pixel = (r_row == RW'(MAX_HEIGHT - 1)) &&
                                 (r_col == CW'(MAX_WIDTH - 1));
    assign o_status.k_last     = (r_k == bit_pkg::NB_LAST);
    assign o_status.changed    = r_changed;
    assign o_status.out_valid  = r_out_valid;

    // Thinning decision on the gathered window.
    assign restore_ok = (int'(r_row) + 2 < hv) && (int'(r_col) + 2 < wv) &&
                        bit_pkg::restore(r_win);
    assign keep    = r_win[4] && (restore_ok || !bit_pkg::any_mask(r_win[8:0]));
    assign removed = r_win[4] && !keep;

    // Store ports: items use the current frame, passes write the other bank.
    assign pass_we = i_cmd.zero_write || i_cmd.eval_write;
    assign raddr   = i_cmd.issue ? nb_addr : item_addr;
    assign waddr   = pass_we ? scan_addr : item_addr;
    assign wdata   = pass_we ? (i_cmd.eval_write && keep) : i_pixel_value;
    assign we0     = (i_cmd.item_write && item_inside && !r_cur) || (pass_we && r_cur);
    assign we1     = (i_cmd.item_write && item_inside && r_cur) || (pass_we && !r_cur);
    assign rdata   = r_cur ? rdata1 : rdata0;

    bit_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (we0),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata0)
    );

    bit_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (we1),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata1)
    );

    // Scan position, neighbor counter and window capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_cap_v <= 1'b0;
        end else begin
            r_cap_v <= i_cmd.issue;
            if (i_cmd.start_run) begin
                r_row <= '0;
                r_col <= '0;
            end else if (pass_we) begin
                if (r_col == CW'(MAX_WIDTH - 1)) begin
                    r_col <= '0;
                    r_row <= (r_row == RW'(MAX_HEIGHT - 1)) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_cmd.gather_start) begin
                r_k <= '0;
            end else if (i_cmd.issue) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_k <= r_k;
        if (r_cap_v) begin
            r_win[r_cap_k] <= rdata;
        end
    end

    // Bank select, change flag and pass counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= 1'b0;
            r_changed <= 1'b0;
            r_count   <= '0;
            r_passes  <= '0;
        end else begin
            if (i_cmd.start_run) begin
                r_changed <= 1'b0;
                r_count   <= '0;
            end else if (i_cmd.finish_pass) begin
                r_cur     <= !r_cur;
                r_changed <= 1'b0;
                if (r_count != 16'hFFFF) begin
                    r_count <= r_count + 16'd1;
                end
            end else if (i_cmd.eval_write && removed) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.run_done) begin
                r_passes <= r_count;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_item || i_cmd.out_load_rd || i_cmd.run_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_read) begin
            r_rd_ok <= item_inside;
        end
        if (i_cmd.out_load_item) begin
            r_out_pix <= 1'b0;
            r_out_cnt <= r_passes;
        end else if (i_cmd.out_load_rd) begin
            r_out_pix <= r_rd_ok && rdata;
            r_out_cnt <= r_passes;
        end else if (i_cmd.run_done) begin
            r_out_pix <= 1'b0;
            r_out_cnt <= r_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_pixel = r_out_pix;
    assign o_pass_count = r_out_cnt;

endmodule

`default_nettype wire

/* design/binary_image_thinning.sv */
// Binary image thinning with a MAX_HEIGHT x MAX_WIDTH frame store held in two
// one-bit RAM banks. A run item makes full passes until one removes nothing;
// each pass sweeps every store location once. A pixel outside the image
// interior is written as zero; an interior pixel is classified, then its eleven
// neighbors are read through the single read port of the frame bank, and after
// the last read returns, its new value is written. Each pass ends with a bank
// swap, and the run ends by delivering the pass count.
// The pass writes the other bank, which then becomes the current frame.
`default_nettype none

module binary_image_thinning #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // operation, row, column, pixel_value
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata   // read_pixel, pass_count
);

    bit_pkg::t_cmd    cmd;
    bit_pkg::t_status status;
    logic             read_pixel;
    logic [15:0]      pass_count;

    bit_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_op      (i_s_tdata[1:0]),
        .i_m_tready(i_m_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    bit_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_row        (i_s_tdata[9:2]),
        .i_column     (i_s_tdata[17:10]),
        .i_pixel_value(i_s_tdata[18]),
        .i_m_tready   (i_m_tready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_m_tvalid),
        .o_read_pixel (read_pixel),
        .o_pass_count (pass_count)
    );

    assign o_m_tdata = {7'd0, pass_count, read_pixel};

endmodule

`default_nettype wire
